// ===== src/pwf_pkg.sv =====
// Shared constants, codes and types of the perceptual weighting filter.
package pwf_pkg;

  // Sizes
  localparam int MAX_ORDER  = 16;
  localparam int HIST_W     = 20;
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ORDER_W    = 5;
  localparam int GAMMA_W    = 16;
  localparam int FRAC_W     = 11;   // Q4.11 coefficients
  localparam int GAMMA_FRAC = 15;   // Q1.15 gamma

  localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int TAP_W  = $clog2(MAX_ORDER + 1);
  localparam int PROD_W = COEF_W + HIST_W;
  localparam int ACC_W  = PROD_W + TAP_W + 1;

  localparam logic [GAMMA_W-1:0] GAMMA_ONE = GAMMA_W'(1 << GAMMA_FRAC);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FACTOR = 1'b1;

  localparam logic [ORDER_W-1:0] FILTER_ORDER_RST  = ORDER_W'(16);
  localparam logic [GAMMA_W-1:0] WEIGHT_FACTOR_RST = GAMMA_W'(29491);

  // Request types
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Sequencer to datapath control
  typedef struct packed {
    logic start;    // sample request accepted: load x and gamma, clear sums
    logic s1_v;     // RAM read data valid
    logic s2_v;     // weighted coefficient and zero product valid
    logic s3_v;     // pole product valid
    logic q_load;   // capture all-pole result
    logic y_load;   // capture output sample
  } pwf_ctrl_t;

endpackage

// ===== src/pwf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/pwf_mac.sv =====
// Tap datapath: gamma powers, weighted coefficients, both sums, q and y.
module pwf_mac (
  input  logic                                   clk,
  input  pwf_pkg::pwf_ctrl_t                     ctrl,
  input  logic [pwf_pkg::GAMMA_W-1:0]            gamma,
  input  logic signed [pwf_pkg::SAMPLE_W-1:0]    sample_in,
  input  logic signed [pwf_pkg::COEF_W-1:0]      coef_rd,
  input  logic signed [pwf_pkg::HIST_W-1:0]      hist_rd,
  output logic signed [pwf_pkg::HIST_W-1:0]      q,
  output logic signed [pwf_pkg::SAMPLE_W-1:0]    y
);
  import pwf_pkg::*;

  localparam logic signed [ACC_W:0] ROUND = (ACC_W+1)'(1 << (FRAC_W - 1));

  logic signed [SAMPLE_W-1:0]      x_r;
  logic [GAMMA_W-1:0]              g_r;
  logic [GAMMA_W-1:0]              g_nxt;
  logic [2*GAMMA_W-1:0]            gg;
  logic signed [GAMMA_W+COEF_W:0]  ga_r, ga_nxt;
  logic signed [PROD_W-1:0]        zp_r, zp_nxt;
  logic signed [PROD_W-1:0]        pp_r, pp_nxt;
  logic signed [HIST_W-1:0]        h_d_r;
  logic signed [COEF_W-1:0]        w;
  logic signed [ACC_W-1:0]         acc_pole_r, acc_zero_r;
  logic signed [HIST_W-1:0]        q_r, q_nxt;
  logic signed [SAMPLE_W-1:0]      y_r, y_nxt;
  logic signed [ACC_W:0]           qsum, qsh, ysum, ysh;
  logic [ACC_W-HIST_W+1:0]         q_top;
  logic [ACC_W-SAMPLE_W+1:0]       y_top;
  logic                            q_fit, y_fit;

  // Stage 1: next gamma power, gamma^j * a[j], a[j] * q[n-j]
  assign gg     = g_r * gamma;
  assign g_nxt  = gg[GAMMA_FRAC +: GAMMA_W];
  assign ga_nxt = $signed({1'b0, g_r}) * coef_rd;
  assign zp_nxt = coef_rd * hist_rd;

  // Stage 2: truncated weighted coefficient times history
  assign w      = ga_r[GAMMA_FRAC +: COEF_W];
  assign pp_nxt = w * h_d_r;

  // All-pole result, rounded and saturated to history width
  assign qsum  = ((ACC_W+1)'(x_r) <<< FRAC_W) - (ACC_W+1)'(acc_pole_r) + ROUND;
  assign qsh   = qsum >>> FRAC_W;
  assign q_top = qsh[ACC_W:HIST_W-1];
  assign q_fit = (&q_top) | ~(|q_top);
  assign q_nxt = q_fit ? qsh[HIST_W-1:0] :
                 (qsh[ACC_W] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}});

  // All-zero result, rounded and saturated to 16 bits
  assign ysum  = ((ACC_W+1)'(q_r) <<< FRAC_W) + (ACC_W+1)'(acc_zero_r) + ROUND;
  assign ysh   = ysum >>> FRAC_W;
  assign y_top = ysh[ACC_W:SAMPLE_W-1];
  assign y_fit = (&y_top) | ~(|y_top);
  assign y_nxt = y_fit ? ysh[SAMPLE_W-1:0] :
                 (ysh[ACC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_r        <= sample_in;
      g_r        <= gamma;
      acc_pole_r <= '0;
      acc_zero_r <= '0;
    end else begin
      if (ctrl.s1_v) begin
        ga_r  <= ga_nxt;
        zp_r  <= zp_nxt;
        h_d_r <= hist_rd;
        g_r   <= g_nxt;
      end
      if (ctrl.s2_v) begin
        pp_r       <= pp_nxt;
        acc_zero_r <= acc_zero_r + ACC_W'(zp_r);
      end
      if (ctrl.s3_v) begin
        acc_pole_r <= acc_pole_r + ACC_W'(pp_r);
      end
      if (ctrl.q_load) begin
        q_r <= q_nxt;
      end
      if (ctrl.y_load) begin
        y_r <= y_nxt;
      end
    end
  end

  assign q = q_r;
  assign y = y_r;

endmodule

// ===== src/pwf_seq.sv =====
// Request sequencer: tap issue, history pointers, result handshake.
module pwf_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [pwf_pkg::ORDER_W-1:0]       in_coef_index,
  input  logic                              in_frame_start,
  input  logic [pwf_pkg::ORDER_W-1:0]       filter_order,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pwf_pkg::pwf_ctrl_t                ctrl,
  output logic                              coef_we,
  output logic [pwf_pkg::IDX_W-1:0]         coef_waddr,
  output logic [pwf_pkg::IDX_W-1:0]         coef_raddr,
  output logic                              hist_we,
  output logic [pwf_pkg::IDX_W-1:0]         hist_waddr,
  output logic [pwf_pkg::IDX_W-1:0]         hist_raddr
);
  import pwf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_QCALC,
    S_YOUT
  } state_t;

  state_t             state_r;
  logic [TAP_W-1:0]   taps_r, cnt_r, vtaps_r;
  logic [IDX_W-1:0]   rp_r, wp_r;
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic               out_valid_r;

  logic               in_fire, sample_fire, issue, y_done;
  logic [TAP_W-1:0]   order_eff, vt_eff, taps_nxt;
  logic [ORDER_W-1:0] coef_idx_m1;

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    if (p == '0) begin
      return IDX_W'(MAX_ORDER - 1);
    end
    return p - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    if (32'(p) == MAX_ORDER - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Handshake
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid & in_ready;
  assign sample_fire = in_fire & (in_req_type == REQ_SAMPLE);
  assign out_valid   = out_valid_r;

  // Coefficient load: out-of-range index is dropped
  assign coef_idx_m1 = in_coef_index - 1'b1;
  assign coef_we     = in_fire && (in_req_type == REQ_COEF) && (in_coef_index != '0)
                       && (32'(in_coef_index) <= MAX_ORDER);
  assign coef_waddr  = coef_idx_m1[IDX_W-1:0];

  // Tap count: order clamped, frame start empties history
  assign order_eff = (32'(filter_order) > MAX_ORDER) ? TAP_W'(MAX_ORDER)
                                                      : TAP_W'(filter_order);
  assign vt_eff    = in_frame_start ? '0 : vtaps_r;
  assign taps_nxt  = (order_eff < vt_eff) ? order_eff : vt_eff;

  // Read issue and history write
  assign issue      = (state_r == S_ISSUE) && (cnt_r != taps_r);
  assign coef_raddr = cnt_r[IDX_W-1:0];
  assign hist_raddr = rp_r;
  assign y_done     = (state_r == S_YOUT) && (!out_valid_r || out_ready);
  assign hist_we    = y_done;
  assign hist_waddr = wp_r;

  assign ctrl.start  = sample_fire;
  assign ctrl.s1_v   = s1_v_r;
  assign ctrl.s2_v   = s2_v_r;
  assign ctrl.s3_v   = s3_v_r;
  assign ctrl.q_load = (state_r == S_QCALC);
  assign ctrl.y_load = y_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taps_r      <= '0;
      cnt_r       <= '0;
      vtaps_r     <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (sample_fire) begin
            state_r <= S_ISSUE;
            taps_r  <= taps_nxt;
            vtaps_r <= vt_eff;
            cnt_r   <= '0;
            rp_r    <= ptr_dec(wp_r);   // newest history entry
          end
        end
        S_ISSUE: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
            rp_r  <= ptr_dec(rp_r);
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            state_r <= S_QCALC;
          end
        end
        S_QCALC: begin
          state_r <= S_YOUT;
        end
        S_YOUT: begin
          if (y_done) begin
            out_valid_r <= 1'b1;
            wp_r        <= ptr_inc(wp_r);
            if (32'(vtaps_r) < MAX_ORDER) begin
              vtaps_r <= vtaps_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lpc_perceptual_weighting_filter_unit.sv =====
// Top level of the perceptual weighting filter A(z)/A(z/gamma).
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid/in_ready, req_type, coef_index,         | request in
//          | coef_value, sample_in, frame_start               |
//  out     | out_valid/out_ready, out_sample_out              | result out
//  cfg     | cfg_we, cfg_index, cfg_wdata                     | write only
//
// A coefficient request does not make the block busy. For a sample request,
// taps is the order capped by the history written since the frame start.
// One coefficient/history RAM read per tap feeds a three-stage
// multiply-accumulate pipeline.
// The result register holds a finished sample while the next request is
// taken; a request completes only once that register is free.
// Reset is synchronous, active low; it empties the history, no clearing pass.
module lpc_perceptual_weighting_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [pwf_pkg::ORDER_W-1:0]          in_coef_index,
  input  logic signed [pwf_pkg::COEF_W-1:0]    in_coef_value,
  input  logic signed [pwf_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pwf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                 cfg_we,
  input  logic [pwf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pwf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pwf_pkg::*;

  logic [ORDER_W-1:0]        filter_order_r;
  logic [GAMMA_W-1:0]        weight_factor_r;
  logic [GAMMA_W-1:0]        gamma;

  pwf_ctrl_t                 ctrl;
  logic                      coef_we, hist_we;
  logic [IDX_W-1:0]          coef_waddr, coef_raddr, hist_waddr, hist_raddr;
  logic [COEF_W-1:0]         coef_rdata;
  logic [HIST_W-1:0]         hist_rdata;
  logic signed [HIST_W-1:0]  q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_order_r  <= FILTER_ORDER_RST;
      weight_factor_r <= WEIGHT_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ORDER:  filter_order_r  <= cfg_wdata[ORDER_W-1:0];
        REG_WEIGHT_FACTOR: weight_factor_r <= cfg_wdata[GAMMA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Gamma above one acts as one
  assign gamma = (weight_factor_r > GAMMA_ONE) ? GAMMA_ONE : weight_factor_r;

  pwf_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_coef_index  (in_coef_index),
    .in_frame_start (in_frame_start),
    .filter_order   (filter_order_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ctrl           (ctrl),
    .coef_we        (coef_we),
    .coef_waddr     (coef_waddr),
    .coef_raddr     (coef_raddr),
    .hist_we        (hist_we),
    .hist_waddr     (hist_waddr),
    .hist_raddr     (hist_raddr)
  );

  // LPC coefficient table
  pwf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Circular history line of q values
  pwf_ram #(.WIDTH(HIST_W), .DEPTH(MAX_ORDER)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (q),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  pwf_mac u_mac (
    .clk       (clk),
    .ctrl      (ctrl),
    .gamma     (gamma),
    .sample_in (in_sample_in),
    .coef_rd   ($signed(coef_rdata)),
    .hist_rd   ($signed(hist_rdata)),
    .q         (q),
    .y         (out_sample_out)
  );

endmodule

// ===== src/pwf_checker.sv =====
// Port-level assertions for the perceptual weighting filter, bound to the top.
module pwf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_req_type,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pwf_pkg::SAMPLE_W-1:0] out_sample_out
);
  import pwf_pkg::*;

  // A result waiting on the consumer keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Coefficient loads never stall the request channel
  a_coef_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_COEF) |=> in_ready)
    else $error("busy after coefficient request");

  // A sample request keeps the block busy for its filter pass
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_SAMPLE)
    |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request taken during filter pass");

endmodule

bind lpc_perceptual_weighting_filter_unit pwf_checker u_pwf_checker (.*);
